/* hdl/sbusd_pkg.sv */
`timescale 1ns / 1ps

package sbusd_pkg;

    // Frame layout
    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [4:0] WAIT_POS   = 5'd31;
    localparam logic [4:0] FLAG_POS   = 5'd23;
    localparam int unsigned HDR_BYTES = 10;  // bytes 0..9 carry the start byte and channels 0..5

    // Raw channel limits
    localparam logic [10:0] RAW_MIN = 11'd172;
    localparam logic [10:0] RAW_MAX = 11'd1810;

    // Output mapping
    localparam logic [10:0] OUT_BASE = 11'd1000;
    localparam logic [11:0] CENTER   = 12'd1500;

    // floor(x * 1000 / 1638) == (x * SCALE_K) >> SCALE_SHIFT for x in 0..1638
    localparam logic [29:0] SCALE_K     = 30'd655520500;
    localparam int unsigned SCALE_SHIFT = 30;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SWITCH_THRESHOLD    = 2'd0,
        REG_DEADZONE_HALF_WIDTH = 2'd1
    } t_reg_idx;

    // Unpacked frame on its way into the mapping pipeline
    typedef struct packed {
        logic [3:0][10:0] offs;   // clamped raw minus RAW_MIN, channels 0..3
        logic             arm;
        logic             kill;
        logic             failsafe;
        logic             frame_lost;
    } t_frame;

    // One decoded result
    typedef struct packed {
        logic [10:0] roll;
        logic [10:0] pitch;
        logic [10:0] throttle;
        logic [10:0] yaw;
        logic [9:0]  throttle_manual;
        logic        arm;
        logic        kill;
        logic        failsafe;
        logic        frame_lost;
    } t_result;

endpackage

/* hdl/sbus_frame_decoder.sv */
`timescale 1ns / 1ps

// Serial receiver frame decoder.
// Input channel (i_valid / o_stall): one received byte per item, with
// i_frame_start set on the first byte after an idle line. A byte is taken in
// every cycle; o_stall rises only when three decoded frames are backed up
// behind a stalled receiver.
// Each frame is FRAME_BYTES bytes. After its last byte, a frame whose first
// byte is 0x0F yields one result item on the output channel
// (o_valid / i_stall); a bad start byte yields nothing. Bytes without
// i_frame_start while no frame is open are dropped.
// The frame passes the unpack register (loaded on the edge that accepts the last
// byte), then the scaling register, then the output register that drives o_valid.
// Throughput: one byte per cycle while o_stall is low; one frame per FRAME_BYTES bytes at most.
// The output register holds its item while i_stall is high.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
// switch threshold, index 1 the dead-zone half width; write only while idle.
// Reset: no frame open, pipeline empty, threshold 500, dead zone 5.
module sbus_frame_decoder #(
    parameter int unsigned FRAME_BYTES = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_roll,
    output logic [10:0] o_pitch,
    output logic [10:0] o_throttle,
    output logic [10:0] o_yaw,
    output logic [9:0]  o_throttle_manual,
    output logic        o_arm,
    output logic        o_kill,
    output logic        o_failsafe,
    output logic        o_frame_lost,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam logic [4:0] LAST_POS = 5'(FRAME_BYTES - 1);

    logic [10:0]          r_threshold;
    logic [8:0]           r_deadzone;
    logic [4:0]           r_pos;
    logic [7:0]           r_hdr [sbusd_pkg::HDR_BYTES];
    logic [7:0]           r_flags;
    logic                 r_v1;
    sbusd_pkg::t_frame    r_frame;

    logic                 take;
    logic                 active;
    logic [4:0]           pos;
    logic                 last_byte;
    logic                 capture;
    logic                 map_ready;
    logic                 s1_ready;
    logic [7:0]           flag_byte;
    logic [10:0]          ch [6];
    sbusd_pkg::t_frame    n_frame;
    sbusd_pkg::t_result   res;

    function automatic logic [10:0] clamp_offset(input logic [10:0] c);
        if (c < sbusd_pkg::RAW_MIN) begin
            return 11'd0;
        end else if (c > sbusd_pkg::RAW_MAX) begin
            return sbusd_pkg::RAW_MAX - sbusd_pkg::RAW_MIN;
        end else begin
            return c - sbusd_pkg::RAW_MIN;
        end
    endfunction

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 11'd500;
            r_deadzone  <= 9'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sbusd_pkg::REG_SWITCH_THRESHOLD:    r_threshold <= i_cfg_data;
                sbusd_pkg::REG_DEADZONE_HALF_WIDTH: r_deadzone  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign s1_ready = !r_v1 || map_ready;
    assign o_stall  = !s1_ready;
    assign take     = i_valid && !o_stall;

    // Byte position: frame start restarts at zero, otherwise continue an open frame
    always_comb begin
        if (i_frame_start) begin
            pos    = 5'd0;
            active = 1'b1;
        end else begin
            pos    = r_pos;
            active = (r_pos < 5'(FRAME_BYTES));
        end
        last_byte = active && (pos == LAST_POS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sbusd_pkg::WAIT_POS;
        end else if (take && active) begin
            r_pos <= last_byte ? sbusd_pkg::WAIT_POS : pos + 5'd1;
        end
    end

    // Store the bytes that are decoded: start byte, channel bytes, flag byte
    always_ff @(posedge i_clk) begin
        if (take && active) begin
            for (int i = 0; i < sbusd_pkg::HDR_BYTES; i++) begin
                if (pos == 5'(i)) begin
                    r_hdr[i] <= i_rx_byte;
                end
            end
            if (pos == sbusd_pkg::FLAG_POS) begin
                r_flags <= i_rx_byte;
            end
        end
    end

    // Unpack 11-bit channels, clamp, compare switches
    always_comb begin
        flag_byte = (pos == sbusd_pkg::FLAG_POS) ? i_rx_byte : r_flags;
        ch[0] = {r_hdr[2][2:0], r_hdr[1]};
        ch[1] = {r_hdr[3][5:0], r_hdr[2][7:3]};
        ch[2] = {r_hdr[5][0], r_hdr[4], r_hdr[3][7:6]};
        ch[3] = {r_hdr[6][3:0], r_hdr[5][7:1]};
        ch[4] = {r_hdr[7][6:0], r_hdr[6][7:4]};
        ch[5] = {r_hdr[9][1:0], r_hdr[8], r_hdr[7][7]};
        for (int k = 0; k < 4; k++) begin
            n_frame.offs[k] = clamp_offset(ch[k]);
        end
        n_frame.arm        = ch[4] > r_threshold;
        n_frame.kill       = ch[5] > r_threshold;
        n_frame.failsafe   = flag_byte[3];
        n_frame.frame_lost = flag_byte[2];
        capture = take && last_byte && (r_hdr[0] == sbusd_pkg::START_BYTE);
    end

    // Unpack register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_ready) begin
            r_v1 <= capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && capture) begin
            r_frame <= n_frame;
        end
    end

    // Scaling, dead zone and output register
    sbusd_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v1),
        .o_ready    (map_ready),
        .i_frame    (r_frame),
        .i_deadzone (r_deadzone),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (res)
    );

    assign o_roll            = res.roll;
    assign o_pitch           = res.pitch;
    assign o_throttle        = res.throttle;
    assign o_yaw             = res.yaw;
    assign o_throttle_manual = res.throttle_manual;
    assign o_arm             = res.arm;
    assign o_kill            = res.kill;
    assign o_failsafe        = res.failsafe;
    assign o_frame_lost      = res.frame_lost;

endmodule

/* hdl/sbusd_map.sv */
`timescale 1ns / 1ps

module sbusd_map (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sbusd_pkg::t_frame     i_frame,
    input  logic [8:0]            i_deadzone,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sbusd_pkg::t_result    o_result
);

    logic              r_v2;
    logic [3:0][9:0]   r_lin;
    logic              r_arm;
    logic              r_kill;
    logic              r_failsafe;
    logic              r_lost;
    logic              r_ov;
    sbusd_pkg::t_result r_res;

    logic              out_ready;
    logic [3:0][9:0]   n_lin;
    logic [40:0]       prod [4];
    logic [3:0][10:0]  n_dead;
    logic [10:0]       mapped;
    sbusd_pkg::t_result n_res;

    // Pipeline handshake: a stage moves when the one after it has room
    assign out_ready = !r_ov || !i_stall;
    assign o_ready   = !r_v2 || out_ready;

    // Scale each channel by 1000/1638 with a reciprocal multiply
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k]  = 41'(i_frame.offs[k]) * 41'(sbusd_pkg::SCALE_K);
            n_lin[k] = prod[k][sbusd_pkg::SCALE_SHIFT +: 10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_ready) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_lin      <= n_lin;
            r_arm      <= i_frame.arm;
            r_kill     <= i_frame.kill;
            r_failsafe <= i_frame.failsafe;
            r_lost     <= i_frame.frame_lost;
        end
    end

    // Offset to 1000..2000 and snap values near center to 1500
    always_comb begin
        mapped = '0;
        for (int k = 0; k < 4; k++) begin
            mapped = 11'(r_lin[k]) + sbusd_pkg::OUT_BASE;
            if ((12'(mapped) + 12'(i_deadzone)) > sbusd_pkg::CENTER &&
                12'(mapped) < (sbusd_pkg::CENTER + 12'(i_deadzone))) begin
                n_dead[k] = 11'(sbusd_pkg::CENTER);
            end else begin
                n_dead[k] = mapped;
            end
        end
        n_res.roll            = n_dead[0];
        n_res.pitch           = n_dead[1];
        n_res.throttle        = n_dead[2];
        n_res.yaw             = n_dead[3];
        n_res.throttle_manual = r_lin[2];
        n_res.arm             = r_arm;
        n_res.kill            = r_kill;
        n_res.failsafe        = r_failsafe;
        n_res.frame_lost      = r_lost;
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_ready) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_v2) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

/* hdl/sbusd_checker.sv */
`timescale 1ns / 1ps

module sbusd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [10:0] o_roll,
    input logic [10:0] o_pitch,
    input logic [10:0] o_throttle,
    input logic [10:0] o_yaw,
    input logic [9:0]  o_throttle_manual
);

    // Hold a stalled result item
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_throttle) && $stable(o_throttle_manual))
        else $error("stalled result changed");

    // Roll, pitch and yaw stay within 1000..2000, manual throttle within 0..1000
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_roll >= 11'd1000 && o_roll <= 11'd2000 &&
                    o_pitch >= 11'd1000 && o_pitch <= 11'd2000 &&
                    o_yaw >= 11'd1000 && o_yaw <= 11'd2000 &&
                    o_throttle_manual <= 10'd1000)
        else $error("mapped value out of range");

    // Throttle is the manual value offset by 1000, or snapped to center
    a_throttle_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_throttle == (11'(o_throttle_manual) + 11'd1000) ||
                    o_throttle == 11'd1500)
        else $error("throttle outputs disagree");

endmodule

bind sbus_frame_decoder sbusd_checker u_sbusd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_roll            (o_roll),
    .o_pitch           (o_pitch),
    .o_throttle        (o_throttle),
    .o_yaw             (o_yaw),
    .o_throttle_manual (o_throttle_manual)
);

/* sim/sbus_frame_decoder_test.sv */
`timescale 1ns / 1ps

module sbus_frame_decoder_test;

    localparam int FRAME_LEN        = 25;
    localparam int STORED_BYTES     = 24;
    localparam int CHAN_TOP         = 2047;
    localparam int RAW_SPAN         = 1638;
    localparam int OUT_SPAN         = 1000;
    localparam int SW_THRESHOLD_RST = 500;
    localparam int DZ_HALF_RST      = 5;
    localparam int SETTLE_CYCLES    = 8;
    localparam int IDLE_LIMIT       = 1000;
    localparam int NUM_PHASES       = 5;
    localparam int PHASE_ITEMS      = 130;
    localparam int PHASE_FRAMES     = 4;
    localparam int DIR_ROWS         = 15;
    localparam int REPORT_LIMIT     = 10;

    // Indexes past the two registers; writes there must change nothing
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_TYPED,
        CHK_NONE
    } t_check;

    typedef struct packed {
        logic [7:0]         head;
        logic [5:0][10:0]   chans;
        logic [7:0]         flags;
        logic [4:0]         cut;     // bytes of an aborted frame sent ahead, 0 for none
        logic [1:0]         noise;   // stray bytes sent while no frame is open
        t_check             how;
        sbusd_pkg::t_result want;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_rx_byte     = 8'h00;
    logic        i_frame_start = 1'b0;
    logic        i_stall       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [10:0] i_cfg_data    = 11'd0;
    logic        o_stall;
    logic        o_valid;
    logic [10:0] o_roll;
    logic [10:0] o_pitch;
    logic [10:0] o_throttle;
    logic [10:0] o_yaw;
    logic [9:0]  o_throttle_manual;
    logic        o_arm;
    logic        o_kill;
    logic        o_failsafe;
    logic        o_frame_lost;
    logic        o_cfg_ready;
    sbusd_pkg::t_result seen;

    // Decoder shadow state and register copies
    logic [4:0]  rx_pos       = sbusd_pkg::WAIT_POS;
    logic [7:0]  rx_mem [STORED_BYTES];
    logic [10:0] sw_threshold = 11'(SW_THRESHOLD_RST);
    logic [8:0]  dz_half      = 9'(DZ_HALF_RST);

    sbusd_pkg::t_result frames_due [$];
    t_dir_row           dir_rows [DIR_ROWS];
    logic [7:0]         frame_buf [FRAME_LEN];
    t_check             row_how;
    sbusd_pkg::t_result row_want;
    bit          no_gaps;
    int          items_sent;
    int          frames_queued;
    int          mismatches;
    int          idle_cycles;
    int          stall_run;
    int          stall_pick;

    sbus_frame_decoder #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_frame_start    (i_frame_start),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_roll           (o_roll),
        .o_pitch          (o_pitch),
        .o_throttle       (o_throttle),
        .o_yaw            (o_yaw),
        .o_throttle_manual(o_throttle_manual),
        .o_arm            (o_arm),
        .o_kill           (o_kill),
        .o_failsafe       (o_failsafe),
        .o_frame_lost     (o_frame_lost),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    assign seen = {o_roll, o_pitch, o_throttle, o_yaw, o_throttle_manual,
                   o_arm, o_kill, o_failsafe, o_frame_lost};

    always #2 i_clk = ~i_clk;

    // Clamp a raw channel and scale it onto 0..1000
    function automatic int scale_chan(input logic [10:0] raw);
        int c;
        c = int'(raw);
        if (c < int'(sbusd_pkg::RAW_MIN)) c = int'(sbusd_pkg::RAW_MIN);
        if (c > int'(sbusd_pkg::RAW_MAX)) c = int'(sbusd_pkg::RAW_MAX);
        return (c - int'(sbusd_pkg::RAW_MIN)) * OUT_SPAN / RAW_SPAN;
    endfunction

    // Scale onto 1000..2000 and snap values near mid-stick to center
    function automatic logic [10:0] stick_chan(input logic [10:0] raw);
        int v;
        int mid;
        mid = int'(sbusd_pkg::CENTER);
        v   = scale_chan(raw) + int'(sbusd_pkg::OUT_BASE);
        if (v + int'(dz_half) > mid && v < mid + int'(dz_half))
            v = mid;
        return 11'(v);
    endfunction

    // Advance the shadow decoder by one byte; returns 1 when a frame decodes
    function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                       output sbusd_pkg::t_result r);
        int               pos;
        int               k;
        logic [71:0]      bits;
        logic [5:0][10:0] ch;
        r = '0;
        if (fs) pos = 0;
        else if (rx_pos != sbusd_pkg::WAIT_POS && int'(rx_pos) < FRAME_LEN)
            pos = int'(rx_pos);
        else return 1'b0;
        if (pos < STORED_BYTES) rx_mem[pos] = b;
        if (pos + 1 < FRAME_LEN) begin
            rx_pos = 5'(pos + 1);
            return 1'b0;
        end
        rx_pos = sbusd_pkg::WAIT_POS;
        if (rx_mem[0] != sbusd_pkg::START_BYTE) return 1'b0;
        // channels are packed LSB first from byte 1 on
        for (k = 1; k <= 9; k++) bits[8*(k-1) +: 8] = rx_mem[k];
        ch = bits[65:0];
        r.roll            = stick_chan(ch[0]);
        r.pitch           = stick_chan(ch[1]);
        r.throttle        = stick_chan(ch[2]);
        r.yaw             = stick_chan(ch[3]);
        r.throttle_manual = 10'(scale_chan(ch[2]));
        r.arm             = ch[4] > sw_threshold;
        r.kill            = ch[5] > sw_threshold;
        r.failsafe        = rx_mem[sbusd_pkg::FLAG_POS][3];
        r.frame_lost      = rx_mem[sbusd_pkg::FLAG_POS][2];
        return 1'b1;
    endfunction

    function automatic sbusd_pkg::t_result mk_res(input int stick, input int manual,
                                                  input logic arm, input logic kill,
                                                  input logic fs, input logic lf);
        sbusd_pkg::t_result r;
        r.roll            = 11'(stick);
        r.pitch           = 11'(stick);
        r.throttle        = 11'(stick);
        r.yaw             = 11'(stick);
        r.throttle_manual = 10'(manual);
        r.arm             = arm;
        r.kill            = kill;
        r.failsafe        = fs;
        r.frame_lost      = lf;
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [7:0] head, input logic [5:0][10:0] chans,
                                        input logic [7:0] flags, input int cut, input int noise,
                                        input t_check how, input sbusd_pkg::t_result want);
        t_dir_row row;
        row.head  = head;
        row.chans = chans;
        row.flags = flags;
        row.cut   = 5'(cut);
        row.noise = 2'(noise);
        row.how   = how;
        row.want  = want;
        return row;
    endfunction

    // Pick a raw channel, biased toward clamp limits, dead-zone edges and the threshold
    function automatic logic [10:0] pick_chan(input bit is_switch);
        int r;
        int v;
        int m;
        r = $urandom_range(0, 99);
        if (r < 30) return 11'($urandom);
        if (is_switch) begin
            v = int'(sw_threshold) + int'($urandom_range(0, 4)) - 2;
        end else if (r < 55) begin
            v = ($urandom_range(0, 1) ? int'(sbusd_pkg::RAW_MIN) : int'(sbusd_pkg::RAW_MAX))
                + int'($urandom_range(0, 6)) - 3;
        end else begin
            m = $urandom_range(0, 1) ? int'(sbusd_pkg::CENTER) + int'(dz_half)
                                     : int'(sbusd_pkg::CENTER) - int'(dz_half);
            v = int'(sbusd_pkg::RAW_MIN) + (m - int'(sbusd_pkg::OUT_BASE)) * RAW_SPAN / OUT_SPAN
                + int'($urandom_range(0, 6)) - 3;
        end
        if (v < 0) v = 0;
        if (v > CHAN_TOP) v = CHAN_TOP;
        return 11'(v);
    endfunction

    function automatic string show(input sbusd_pkg::t_result r);
        return {$sformatf("roll %0d pitch %0d throttle %0d yaw %0d manual %0d",
                          r.roll, r.pitch, r.throttle, r.yaw, r.throttle_manual),
                $sformatf(" arm %0b kill %0b fs %0b lost %0b",
                          r.arm, r.kill, r.failsafe, r.frame_lost)};
    endfunction

    // Lay out one frame: head byte, channels 0..5, random upper channels, flags, end byte
    task automatic build_frame(input logic [7:0] head, input logic [5:0][10:0] chans,
                               input logic [7:0] flags);
        logic [175:0] s;
        int           k;
        for (k = 0; k < 22; k++) s[8*k +: 8] = 8'($urandom);
        s[65:0] = chans;
        frame_buf[0] = head;
        for (k = 1; k <= 22; k++) frame_buf[k] = s[8*(k-1) +: 8];
        frame_buf[sbusd_pkg::FLAG_POS] = flags;
        frame_buf[FRAME_LEN - 1]       = 8'($urandom);
    endtask

    // Hold the byte until taken, then queue what it decodes to
    task automatic send_byte(input logic [7:0] b, input logic fs, input bit closes_row);
        sbusd_pkg::t_result r;
        bit                 hit;
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
        hit = decode_byte(b, fs, r);
        if (closes_row && row_how != CHK_PREDICT) begin
            if (row_how == CHK_TYPED) begin
                frames_due.push_back(row_want);
                frames_queued++;
            end
        end else if (hit) begin
            frames_due.push_back(r);
            frames_queued++;
        end
    endtask

    // Drop valid for a random gap: mostly none or short, now and then long
    task automatic pause_sender();
        int r;
        int n;
        if (no_gaps) return;
        r = $urandom_range(0, 99);
        n = (r < 70) ? 0 : (r < 95) ? int'($urandom_range(1, 4)) : int'($urandom_range(10, 60));
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Send stray bytes, an aborted frame, then the frame in frame_buf
    task automatic send_frame(input int noise, input int cut);
        int         k;
        logic [7:0] first;
        for (k = 0; k < noise; k++) begin
            send_byte(8'($urandom), 1'b0, 1'b0);
            items_sent++;
            pause_sender();
        end
        for (k = 0; k < cut; k++) begin
            if (k == 0) begin
                first = $urandom_range(0, 1) ? sbusd_pkg::START_BYTE : 8'($urandom);
                send_byte(first, 1'b1, 1'b0);
            end else begin
                send_byte(8'($urandom), 1'b0, 1'b0);
            end
            items_sent++;
            pause_sender();
        end
        for (k = 0; k < FRAME_LEN; k++) begin
            send_byte(frame_buf[k], k == 0, k == FRAME_LEN - 1);
            items_sent++;
            pause_sender();
        end
    endtask

    task automatic random_frame();
        int               r;
        int               k;
        int               noise;
        int               cut;
        logic [7:0]       head;
        logic [5:0][10:0] ch;
        r     = $urandom_range(0, 99);
        head  = sbusd_pkg::START_BYTE;
        noise = 0;
        cut   = 0;
        if (r >= 80 && r < 88) begin
            do head = 8'($urandom); while (head == sbusd_pkg::START_BYTE);
        end else if (r >= 88 && r < 96) begin
            cut = $urandom_range(1, STORED_BYTES);
        end else if (r >= 96) begin
            noise = $urandom_range(1, 6);
        end
        for (k = 0; k < 4; k++) ch[k] = pick_chan(1'b0);
        ch[4] = pick_chan(1'b1);
        ch[5] = pick_chan(1'b1);
        build_frame(head, ch, 8'($urandom));
        no_gaps = ($urandom_range(0, 3) == 0);
        row_how = CHK_PREDICT;
        send_frame(noise, cut);
    endtask

    // Stop sending and wait until the decoder has gone quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == sbusd_pkg::REG_SWITCH_THRESHOLD) sw_threshold = data;
        else if (idx == sbusd_pkg::REG_DEADZONE_HALF_WIDTH) dz_half = data[8:0];
    endtask

    task automatic check_frame(input sbusd_pkg::t_result got);
        sbusd_pkg::t_result want;
        if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected result: %s", $time, show(got));
            return;
        end
        want = frames_due.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: result mismatch", $time);
                $display("  expected %s", show(want));
                $display("  actual   %s", show(got));
            end
        end
    endtask

    // Check every result the receiver takes
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_frame(seen);
    end

    // Receiver back-pressure: alternate runs of stall and flow
    always @(posedge i_clk) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (i_stall) begin
            i_stall   <= 1'b0;
            stall_run <= (stall_pick < 10) ? int'($urandom_range(100, 300))
                                           : int'($urandom_range(0, 12));
        end else begin
            i_stall   <= 1'b1;
            stall_run <= (stall_pick < 8) ? int'($urandom_range(20, 80))
                                          : int'($urandom_range(0, 3));
        end
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("sbus_frame_decoder_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        int k;
        int start;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_pos       = sbusd_pkg::WAIT_POS;
        sw_threshold = 11'(SW_THRESHOLD_RST);
        dz_half      = 9'(DZ_HALF_RST);

        // Directed frames under reset settings: extremes, switch edges, bad heads,
        // stray bytes, restarts mid-frame
        dir_rows[0]  = mk_row(sbusd_pkg::START_BYTE, '0, 8'h00, 0, 0, CHK_TYPED,
                              mk_res(1000, 0, 0, 0, 0, 0));
        dir_rows[1]  = mk_row(sbusd_pkg::START_BYTE, '1, 8'hFF, 0, 0, CHK_TYPED,
                              mk_res(2000, 1000, 1, 1, 1, 1));
        dir_rows[2]  = mk_row(sbusd_pkg::START_BYTE, {6{sbusd_pkg::RAW_MIN}}, 8'h08, 0, 0,
                              CHK_TYPED, mk_res(1000, 0, 0, 0, 1, 0));
        dir_rows[3]  = mk_row(sbusd_pkg::START_BYTE, {6{sbusd_pkg::RAW_MAX}}, 8'h04, 0, 0,
                              CHK_TYPED, mk_res(2000, 1000, 1, 1, 0, 1));
        dir_rows[4]  = mk_row(sbusd_pkg::START_BYTE, {6{11'd171}}, 8'h00, 0, 0, CHK_TYPED,
                              mk_res(1000, 0, 0, 0, 0, 0));
        dir_rows[5]  = mk_row(sbusd_pkg::START_BYTE, {6{11'd1811}}, 8'h00, 0, 0, CHK_TYPED,
                              mk_res(2000, 1000, 1, 1, 0, 0));
        dir_rows[6]  = mk_row(sbusd_pkg::START_BYTE, {11'd501, 11'd500, {4{11'd0}}}, 8'h00,
                              0, 0, CHK_TYPED, mk_res(1000, 0, 0, 1, 0, 0));
        dir_rows[7]  = mk_row(sbusd_pkg::START_BYTE, {11'd500, 11'd501, 11'd983, 11'd997,
                              11'd985, 11'd991}, 8'hF3, 0, 0, CHK_PREDICT, '0);
        dir_rows[8]  = mk_row(8'h00, 66'({$urandom, $urandom, $urandom}), 8'($urandom),
                              0, 0, CHK_NONE, '0);
        dir_rows[9]  = mk_row(8'h8F, 66'({$urandom, $urandom, $urandom}), 8'($urandom),
                              0, 0, CHK_NONE, '0);
        dir_rows[10] = mk_row(sbusd_pkg::START_BYTE, 66'({$urandom, $urandom, $urandom}),
                              8'($urandom), 0, 3, CHK_PREDICT, '0);
        dir_rows[11] = mk_row(sbusd_pkg::START_BYTE, 66'({$urandom, $urandom, $urandom}),
                              8'($urandom), 12, 0, CHK_PREDICT, '0);
        dir_rows[12] = mk_row(sbusd_pkg::START_BYTE, 66'({$urandom, $urandom, $urandom}),
                              8'($urandom), STORED_BYTES, 0, CHK_PREDICT, '0);
        dir_rows[13] = mk_row(sbusd_pkg::START_BYTE, 66'({$urandom, $urandom, $urandom}),
                              8'($urandom), 1, 0, CHK_PREDICT, '0);
        dir_rows[14] = mk_row(sbusd_pkg::START_BYTE, 66'({$urandom, $urandom, $urandom}),
                              8'($urandom), 0, 1, CHK_PREDICT, '0);

        for (k = 0; k < DIR_ROWS; k++) begin
            build_frame(dir_rows[k].head, dir_rows[k].chans, dir_rows[k].flags);
            row_how  = dir_rows[k].how;
            row_want = dir_rows[k].want;
            no_gaps  = (k % 2 == 0);
            send_frame(int'(dir_rows[k].noise), int'(dir_rows[k].cut));
        end

        // Random frames, one register setting per phase
        for (p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(sbusd_pkg::REG_SWITCH_THRESHOLD, 11'd0);
                    write_reg(sbusd_pkg::REG_DEADZONE_HALF_WIDTH, 11'd0);
                end
                1: begin
                    write_reg(sbusd_pkg::REG_SWITCH_THRESHOLD, 11'd2047);
                    write_reg(sbusd_pkg::REG_DEADZONE_HALF_WIDTH, 11'd500);
                end
                2: begin
                    write_reg(REG_SPARE_2, 11'($urandom));
                    write_reg(sbusd_pkg::REG_SWITCH_THRESHOLD, 11'($urandom));
                    write_reg(sbusd_pkg::REG_DEADZONE_HALF_WIDTH,
                              11'($urandom_range(0, 500)));
                    write_reg(REG_SPARE_3, 11'($urandom));
                end
                3: begin
                    write_reg(sbusd_pkg::REG_SWITCH_THRESHOLD, 11'd1024);
                    write_reg(sbusd_pkg::REG_DEADZONE_HALF_WIDTH, 11'd1);
                end
                default: begin
                    write_reg(sbusd_pkg::REG_DEADZONE_HALF_WIDTH, 11'(DZ_HALF_RST));
                    write_reg(REG_SPARE_3, 11'h7FF);
                    write_reg(sbusd_pkg::REG_SWITCH_THRESHOLD, 11'(SW_THRESHOLD_RST));
                end
            endcase
            i_cfg_valid <= 1'b0;
            items_sent = 0;
            start      = frames_queued;
            while (items_sent < PHASE_ITEMS || frames_queued - start < PHASE_FRAMES)
                random_frame();
        end

        settle();
        if (mismatches == 0 && frames_due.size() == 0)
            $display("sbus_frame_decoder_test: PASS");
        else
            $display("sbus_frame_decoder_test: FAIL");
        $finish;
    end

endmodule
